// File: rtl/rsi_pkg.sv
package rsi_pkg;

   parameter int FRAC_BITS_DEF = 16;

   // reset radius is 1.0 in unsigned Q15.16
   localparam logic [30:0] RADIUS_RESET = 31'd65536;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_QBITS  = 32;
   localparam int DIV_REM_W  = 66;

   localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
   localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

   typedef struct packed {
      logic signed [31:0] t_lo;
      logic signed [31:0] t_hi;
      logic               miss;
      logic               dzero;
   } win_type;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] h;
      logic signed [31:0] c;
      win_type            win;
   } coef_type;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/rsi_quad.sv
module rsi_quad
   import rsi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2:0][31:0] org_in,
   input  logic [2:0][31:0] dir_in,
   input  logic [31:0]     t_lo_in,
   input  logic [31:0]     t_hi_in,
   input  logic [30:0]     radius,
   output logic            out_valid,
   output logic [63:0]     disc,
   output coef_type        coef
);

   // stage 1: products
   logic signed [63:0] dd_ff [3];
   logic signed [63:0] do_ff [3];
   logic signed [63:0] oo_ff [3];
   logic [61:0]        rr_ff;
   logic [31:0]        lo1_ff, hi1_ff;
   logic               v1_ff;

   // stage 2: a, h, c
   logic signed [31:0] a2_ff, h2_ff, c2_ff;
   logic [31:0]        lo2_ff, hi2_ff;
   logic               v2_ff;
   logic signed [67:0] a_sum, h_sum, c_sum;

   // stage 3: h*h and a*c
   logic signed [63:0] hh_ff, ac_ff;
   logic signed [31:0] a3_ff, h3_ff, c3_ff;
   logic [31:0]        lo3_ff, hi3_ff;
   logic               v3_ff;

   // stage 4: discriminant
   logic signed [63:0] disc_in;
   logic [63:0]        disc_ff;
   coef_type           coef_ff;
   logic               v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dd_ff[i] <= $signed(dir_in[i]) * $signed(dir_in[i]);
            do_ff[i] <= $signed(dir_in[i]) * $signed(org_in[i]);
            oo_ff[i] <= $signed(org_in[i]) * $signed(org_in[i]);
         end
         rr_ff  <= 62'(radius) * 62'(radius);
         lo1_ff <= t_lo_in;
         hi1_ff <= t_hi_in;
      end
   end

   // arithmetic shift is the floor of the scaled product
   always_comb begin
      a_sum = '0;
      h_sum = '0;
      c_sum = '0;
      for (int i = 0; i < 3; i++) begin
         a_sum = a_sum + 68'(dd_ff[i] >>> FRAC_BITS);
         h_sum = h_sum + 68'(do_ff[i] >>> FRAC_BITS);
         c_sum = c_sum + 68'(oo_ff[i] >>> FRAC_BITS);
      end
      c_sum = c_sum - $signed(68'(rr_ff >> FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_ff  <= sat32(a_sum);
         h2_ff  <= sat32(h_sum);
         c2_ff  <= sat32(c_sum);
         lo2_ff <= lo1_ff;
         hi2_ff <= hi1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff  <= h2_ff * h2_ff;
         ac_ff  <= a2_ff * c2_ff;
         a3_ff  <= a2_ff;
         h3_ff  <= h2_ff;
         c3_ff  <= c2_ff;
         lo3_ff <= lo2_ff;
         hi3_ff <= hi2_ff;
      end
   end

   // h*h <= 2^62 and -a*c <= 2^62, so the difference fits 64 bits
   assign disc_in = hh_ff - ac_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         disc_ff            <= disc_in;
         coef_ff.a          <= a3_ff;
         coef_ff.h          <= h3_ff;
         coef_ff.c          <= c3_ff;
         coef_ff.win.t_lo   <= lo3_ff;
         coef_ff.win.t_hi   <= hi3_ff;
         coef_ff.win.miss   <= (a3_ff == 32'sd0) || disc_in[63];
         coef_ff.win.dzero  <= (disc_in == 64'sd0);
      end
   end

   assign out_valid = v4_ff;
   assign disc      = disc_ff;
   assign coef      = coef_ff;

endmodule

// File: rtl/rsi_sqrt.sv
module rsi_sqrt
   import rsi_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [63:0]       radicand,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [31:0]       root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STEPS = SQRT_STEPS;
   localparam int RW    = 36;

   logic [RW-1:0]     rem_ff  [STEPS];
   logic [31:0]       root_ff [STEPS];
   logic [63:0]       rad_ff  [STEPS];
   logic              vld_ff  [STEPS];
   logic [SIDE_W-1:0] side_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [RW-1:0]     rem_prev, rem_sh, trial;
      logic [31:0]       root_prev;
      logic [63:0]       rad_prev;
      logic              vld_prev;
      logic [SIDE_W-1:0] side_prev;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
         assign vld_prev  = in_valid;
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh = {rem_prev[RW-3:0], rad_prev[63:62]};
      assign trial  = {{(RW-34){1'b0}}, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_sh >= trial) begin
               rem_ff[k]  <= rem_sh - trial;
               root_ff[k] <= {root_prev[30:0], 1'b1};
            end else begin
               rem_ff[k]  <= rem_sh;
               root_ff[k] <= {root_prev[30:0], 1'b0};
            end
            rad_ff[k]  <= {rad_prev[61:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign root      = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// File: rtl/rsi_div.sv
module rsi_div
   import rsi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int SIDE_W    = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [1:0][33:0]  num_in,
   input  logic [1:0][33:0]  den_in,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [1:0][31:0]  quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int QB = DIV_QBITS;
   localparam int RW = DIV_REM_W;

   // prep stage: magnitudes, sign, overflow of the quotient range
   logic [1:0][RW-1:0] n_sh, d_sh;
   logic [1:0][33:0]   n_abs, d_abs;
   logic [1:0][RW-1:0] p_rem_ff;
   logic [1:0][33:0]   p_den_ff;
   logic [1:0]         p_neg_ff, p_ovf_ff;
   logic               p_vld_ff;
   logic [SIDE_W-1:0]  p_side_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         n_abs[l] = num_in[l][33] ? 34'(-num_in[l]) : num_in[l];
         d_abs[l] = den_in[l][33] ? 34'(-den_in[l]) : den_in[l];
         n_sh[l]  = RW'(n_abs[l]) << FRAC_BITS;
         d_sh[l]  = RW'(d_abs[l]) << QB;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            p_rem_ff[l] <= n_sh[l];
            p_den_ff[l] <= d_abs[l];
            p_neg_ff[l] <= num_in[l][33] ^ den_in[l][33];
            p_ovf_ff[l] <= n_sh[l] >= d_sh[l];
         end
         p_side_ff <= in_side;
      end
   end

   // restoring steps, one quotient bit per stage, MSB first
   logic [1:0][RW-1:0] rem_ff  [QB];
   logic [1:0][33:0]   den_ff  [QB];
   logic [1:0][31:0]   q_ff    [QB];
   logic [1:0]         neg_ff  [QB];
   logic [1:0]         ovf_ff  [QB];
   logic               vld_ff  [QB];
   logic [SIDE_W-1:0]  side_ff [QB];

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [1:0][RW-1:0] rem_prev;
      logic [1:0][33:0]   den_prev;
      logic [1:0][31:0]   q_prev;
      logic [1:0]         neg_prev, ovf_prev;
      logic               vld_prev;
      logic [SIDE_W-1:0]  side_prev;
      logic [1:0][RW-1:0] sub;

      if (k == 0) begin : g_first
         assign rem_prev  = p_rem_ff;
         assign den_prev  = p_den_ff;
         assign q_prev    = '0;
         assign neg_prev  = p_neg_ff;
         assign ovf_prev  = p_ovf_ff;
         assign vld_prev  = p_vld_ff;
         assign side_prev = p_side_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign neg_prev  = neg_ff[k-1];
         assign ovf_prev  = ovf_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            sub[l] = RW'(den_prev[l]) << (QB - 1 - k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 2; l++) begin
               if (rem_prev[l] >= sub[l]) begin
                  rem_ff[k][l] <= rem_prev[l] - sub[l];
                  q_ff[k][l]   <= {q_prev[l][30:0], 1'b1};
               end else begin
                  rem_ff[k][l] <= rem_prev[l];
                  q_ff[k][l]   <= {q_prev[l][30:0], 1'b0};
               end
            end
            den_ff[k]  <= den_prev;
            neg_ff[k]  <= neg_prev;
            ovf_ff[k]  <= ovf_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   // apply sign, saturate to the signed 32-bit range
   logic [1:0][31:0]  res_in;
   logic [1:0][31:0]  res_ff;
   logic              res_vld_ff;
   logic [SIDE_W-1:0] res_side_ff;
   logic [1:0][31:0]  qv;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         qv[l] = q_ff[QB-1][l];
         if (ovf_ff[QB-1][l]) begin
            res_in[l] = neg_ff[QB-1][l] ? 32'h8000_0000 : 32'h7fff_ffff;
         end else if (neg_ff[QB-1][l]) begin
            res_in[l] = (qv[l] > 32'h8000_0000) ? 32'h8000_0000 : 32'(-qv[l]);
         end else begin
            res_in[l] = qv[l][31] ? 32'h7fff_ffff : qv[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
      end else if (en) begin
         res_vld_ff <= vld_ff[QB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff      <= res_in;
         res_side_ff <= side_ff[QB-1];
      end
   end

   assign out_valid = res_vld_ff;
   assign quo       = res_ff;
   assign out_side  = res_side_ff;

endmodule

// File: rtl/ray_sphere_intersect_top.sv
// Throughput: one request per cycle while no skid entry is held (req_tready high);
// the depth is set by the 32-stage square root and the 32-stage dividers, each
// retiring one result bit per stage.
// A one-entry skid register behind the output keeps req_tready registered.
// Reset (synchronous, active high) empties the pipeline and sets the radius to 1.0.
module ray_sphere_intersect_top
   import rsi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit, hit_distance[32:1], zero pad
   output logic [39:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [30:0]  csr_wr_data
);

   localparam logic signed [31:0] EPS = 32'(((1 << FRAC_BITS) + 50) / 100);
   localparam int COEF_W = $bits(coef_type);
   localparam int WIN_W  = $bits(win_type);

   logic [30:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   logic skid_vld_ff;
   logic en;

   assign en         = !skid_vld_ff;
   assign req_tready = en;

   // quadratic coefficients and discriminant
   logic [2:0][31:0] org, dir;
   logic             qd_vld;
   logic [63:0]      qd_disc;
   coef_type         qd_coef;

   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign org[i] = req_tdata[32*i +: 32];
      assign dir[i] = req_tdata[32*(i+3) +: 32];
   end

   rsi_quad #(
      .FRAC_BITS (FRAC_BITS)
   ) u_quad (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid && req_tready),
      .org_in    (org),
      .dir_in    (dir),
      .t_lo_in   (req_tdata[223:192]),
      .t_hi_in   (req_tdata[255:224]),
      .radius    (radius_ff),
      .out_valid (qd_vld),
      .disc      (qd_disc),
      .coef      (qd_coef)
   );

   logic              sq_vld;
   logic [31:0]       sq_root;
   logic [COEF_W-1:0] sq_side;
   coef_type          sq_coef;

   rsi_sqrt #(
      .SIDE_W (COEF_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (qd_vld),
      .radicand  (qd_disc),
      .in_side   (qd_coef),
      .out_valid (sq_vld),
      .root      (sq_root),
      .out_side  (sq_side)
   );

   assign sq_coef = coef_type'(sq_side);

   // q = -(h + s) when h > 0, else s - h
   logic signed [33:0] hx, sx, q_in;
   logic signed [33:0] q_ff;
   logic signed [31:0] qa_ff, qc_ff;
   win_type            qwin_ff;
   logic               qvld_ff;

   assign hx   = 34'(sq_coef.h);
   assign sx   = $signed({2'b00, sq_root});
   assign q_in = (sq_coef.h > 32'sd0) ? -(hx + sx) : (sx - hx);

   always_ff @(posedge clock) begin
      if (reset) begin
         qvld_ff <= 1'b0;
      end else if (en) begin
         qvld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff    <= q_in;
         qa_ff   <= sq_coef.a;
         qc_ff   <= sq_coef.c;
         qwin_ff <= sq_coef.win;
      end
   end

   // lane 0: q/a, lane 1: c/q
   logic [1:0][33:0]  dv_num, dv_den;
   logic              dv_vld;
   logic [1:0][31:0]  dv_quo;
   logic [WIN_W-1:0]  dv_side;
   win_type           dv_win;

   assign dv_num[0] = q_ff;
   assign dv_den[0] = 34'(qa_ff);
   assign dv_num[1] = 34'(qc_ff);
   assign dv_den[1] = q_ff;

   rsi_div #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (WIN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (qvld_ff),
      .num_in    (dv_num),
      .den_in    (dv_den),
      .in_side   (qwin_ff),
      .out_valid (dv_vld),
      .quo       (dv_quo),
      .out_side  (dv_side)
   );

   assign dv_win = win_type'(dv_side);

   // pick the nearer non-negative root and test it against EPS and the window
   logic signed [31:0] t0, t1, t_near, t_far, t_sel;
   logic               hit_in;
   logic               fin_vld_ff, fin_hit_ff;
   logic [31:0]        fin_dist_ff;

   always_comb begin
      t0     = $signed(dv_quo[0]);
      t1     = dv_win.dzero ? $signed(dv_quo[0]) : $signed(dv_quo[1]);
      t_near = (t0 > t1) ? t1 : t0;
      t_far  = (t0 > t1) ? t0 : t1;
      t_sel  = t_near[31] ? t_far : t_near;
      hit_in = !dv_win.miss && !t_sel[31] && (t_sel > EPS)
               && (t_sel > dv_win.t_lo) && (t_sel < dv_win.t_hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (en) begin
         fin_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_hit_ff  <= hit_in;
         fin_dist_ff <= hit_in ? t_sel : 32'd0;
      end
   end

   // output register with one skid entry
   logic        out_vld_ff, out_hit_ff, skid_hit_ff;
   logic [31:0] out_dist_ff, skid_dist_ff;
   logic        out_free;

   assign out_free = !out_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_free) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (fin_vld_ff) begin
         if (out_free) begin
            out_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_free) begin
            out_hit_ff  <= skid_hit_ff;
            out_dist_ff <= skid_dist_ff;
         end
      end else if (fin_vld_ff) begin
         if (out_free) begin
            out_hit_ff  <= fin_hit_ff;
            out_dist_ff <= fin_dist_ff;
         end else begin
            skid_hit_ff  <= fin_hit_ff;
            skid_dist_ff <= fin_dist_ff;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_dist_ff, out_hit_ff};

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry held while output register empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && !rsp_tready |=> skid_vld_ff && $stable(skid_dist_ff))
      else $error("skid entry lost under stall");

   a_hit_above_eps: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_hit_ff |-> $signed(out_dist_ff) > EPS)
      else $error("hit reported at or below minimum distance");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_hit_ff |-> out_dist_ff == 32'd0)
      else $error("miss carries a nonzero distance");

endmodule

// File: tb/sv/ray_sphere_checker.sv
module ray_sphere_checker
   import rsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [255:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [30:0]  csr_wr_data,
   output int           fail_count,
   output int           rays_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     FB       = 16;
   localparam longint HIT_EPS  = ((64'sd1 <<< FB) + 50) / 100;

   typedef struct {
      logic               hit;
      logic signed [31:0] hit_dist;
   } hit_result_type;

   hit_result_type expected_hits[$];
   logic [30:0] radius_q;

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint dot_fx(input longint p[3], input longint q[3]);
      longint acc;
      acc = 0;
      for (int i = 0; i < 3; i++) acc += (p[i] * q[i]) >>> FB;
      return acc;
   endfunction

   function automatic longint floor_sqrt(input longint unsigned n);
      longint unsigned root, bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > n) bitpos >>= 2;
      while (bitpos != 0) begin
         if (n >= root + bitpos) begin
            n -= root + bitpos;
            root = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return longint'(root);
   endfunction

   function automatic longint quot_fx(input longint num, input longint den);
      return clamp32((num * (64'sd1 <<< FB)) / den);
   endfunction

   function automatic hit_result_type intersect_sphere(input logic [255:0] ray,
                                                      input logic [30:0] radius);
      hit_result_type res;
      longint org[3], dir[3];
      longint a, h, c, disc, s, q, t0, t1, tmp, t_lo, t_hi, r2;
      res.hit = 1'b0;
      res.hit_dist = '0;
      for (int i = 0; i < 3; i++) begin
         org[i] = longint'($signed(ray[32*i +: 32]));
         dir[i] = longint'($signed(ray[32*(i+3) +: 32]));
      end
      t_lo = longint'($signed(ray[223:192]));
      t_hi = longint'($signed(ray[255:224]));
      a = clamp32(dot_fx(dir, dir));
      h = clamp32(dot_fx(dir, org));
      r2 = (longint'({33'd0, radius}) * longint'({33'd0, radius})) >>> FB;
      c = clamp32(dot_fx(org, org) - r2);
      if (a <= 0) return res;
      disc = h * h - a * c;
      if (disc < 0) return res;
      if (disc == 0) begin
         t0 = quot_fx(-h, a);
         t1 = t0;
      end else begin
         s = floor_sqrt(longint'(disc));
         q = (h > 0) ? -(h + s) : (s - h);
         t0 = quot_fx(q, a);
         t1 = quot_fx(c, q);
      end
      if (t0 > t1) begin
         tmp = t0;
         t0 = t1;
         t1 = tmp;
      end
      if (t0 < 0) t0 = t1;
      if (t0 < 0) return res;
      if (t0 > HIT_EPS && t0 > t_lo && t0 < t_hi) begin
         res.hit = 1'b1;
         res.hit_dist = t0[31:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      hit_result_type exp_r;
      if (reset) begin
         radius_q <= RADIUS_RESET;
         expected_hits.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_hits.push_back(intersect_sphere(req_tdata, radius_q));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_hits.pop_front();
               if (rsp_tdata[0] !== exp_r.hit || rsp_tdata[32:1] !== exp_r.hit_dist
                   || rsp_tdata[39:33] !== 7'd0) begin
                  $display("%0t: mismatch expected hit=%b dist=%0d actual hit=%b dist=%0d pad=%h",
                           $time, exp_r.hit, exp_r.hit_dist, rsp_tdata[0],
                           $signed(rsp_tdata[32:1]), rsp_tdata[39:33]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_wr_en) radius_q <= csr_wr_data;
      end
      rays_in_flight <= expected_hits.size();
   end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ONE        = 65536;
   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN      = 100;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic [30:0]  csr_wr_data = '0;
   int           fail_count;
   int           rays_in_flight;
   int           hold_rsp = 0;
   int           holds_done = 0;
   int           burst_left = 0;
   int           idle_cycles = 0;

   always #2 clock = ~clock;

   ray_sphere_intersect_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   ray_sphere_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .rays_in_flight(rays_in_flight)
   );

   function automatic logic [255:0] pack_ray(input int ox, oy, oz, dx, dy, dz, tl, tu);
      return {tu, tl, dz, dy, dx, oz, oy, ox};
   endfunction

   function automatic int jitter(input int span);
      return $urandom_range(2 * span) - span;
   endfunction

   // mostly rays aimed near the sphere, plus noise and extremes
   function automatic logic [255:0] random_ray();
      int ox, oy, oz, sel;
      int tl, tu;
      sel = $urandom_range(99);
      ox = jitter(6 * ONE);
      oy = jitter(6 * ONE);
      oz = jitter(6 * ONE);
      tl = ($urandom_range(3) == 0) ? jitter(4 * ONE) : 0;
      tu = ($urandom_range(5) == 0) ? jitter(8 * ONE) : 32'sh7fffffff;
      if (sel < 60)
         return pack_ray(ox, oy, oz, -ox + jitter(ONE), -oy + jitter(ONE),
                         -oz + jitter(ONE), tl, tu);
      if (sel < 75)
         return {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
      if (sel < 85)
         return pack_ray(ox, oy, oz, jitter(300), jitter(300), jitter(300), tl, tu);
      if (sel < 92)
         return pack_ray(ox >>> $urandom_range(3), oy, oz,
                         jitter(ONE / 4), jitter(ONE / 4), jitter(ONE / 4), tl, tu);
      return pack_ray($urandom_range(1) ? 32'sh7fffffff : 32'sh80000000,
                      jitter(ONE), $urandom,
                      $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000,
                      jitter(ONE), $urandom, $urandom, $urandom);
   endfunction

   task automatic send_ray(input logic [255:0] ray);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= ray;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_rays();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rays_in_flight != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_radius(input logic [30:0] r);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // receiver: stall pattern picked at random from four modes, plus a long hold on demand
   initial begin
      int mode;
      @(negedge reset);
      forever begin
         mode = $urandom_range(3);
         for (int i = 0; i < 64; i++) begin
            @(posedge clock);
            if (hold_rsp != holds_done) begin
               rsp_tready <= 1'b0;
               repeat (400) @(posedge clock);
               holds_done++;
            end
            case (mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(1));
               end
               2: begin
                  rsp_tready <= ($urandom_range(4) == 0);
               end
               default: begin
                  rsp_tready <= (i % 8) < 5;
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [30:0] radii[6];
      radii = '{31'd0, 31'h7fffffff, 31'd1, 31'd32768, 31'(3 * ONE), 31'd12345678};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rays at the reset radius
      send_ray(pack_ray(0, 0, -5 * ONE, 0, 0, 0, 0, 32'sh7fffffff));
      send_ray(pack_ray(0, 0, -5 * ONE, 0, 0, ONE, 0, 32'sh7fffffff));
      send_ray(pack_ray(0, ONE, -5 * ONE, 0, 0, ONE, 0, 32'sh7fffffff));
      send_ray(pack_ray(0, 2 * ONE, -5 * ONE, 0, 0, ONE, 0, 32'sh7fffffff));
      send_ray(pack_ray(0, 0, 5 * ONE, 0, 0, ONE, 0, 32'sh7fffffff));
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 0, 32'sh7fffffff));
      send_ray(pack_ray(0, 0, -5 * ONE, 0, 0, ONE, 10 * ONE, 2 * ONE));
      send_ray(pack_ray(0, 0, -5 * ONE, 0, 0, ONE, 4 * ONE, 4 * ONE));
      send_ray(pack_ray(0, 0, -5 * ONE, 0, 0, ONE, 0, 4 * ONE));
      send_ray(pack_ray(0, 0, -ONE - 300, 0, 0, ONE, 0, 32'sh7fffffff));
      send_ray(pack_ray(0, 0, -5 * ONE, 0, 0, 100, 0, 32'sh7fffffff));
      send_ray(pack_ray(0, 0, -5 * ONE, 0, 0, 1, 0, 32'sh7fffffff));
      send_ray({8{32'h7fffffff}});
      send_ray({8{32'h80000000}});
      send_ray({8{32'hffffffff}});
      send_ray({8{32'h00000000}});
      send_ray(pack_ray(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff,
                        1, 32'sh80000000, 32'sh7fffffff));
      for (int i = 0; i < 150; i++) send_ray(random_ray());
      drain_rays();

      for (int p = 0; p < 6; p++) begin
         write_radius(radii[p]);
         for (int i = 0; i < 225; i++) begin
            if (p == 2 && i == 20) hold_rsp++;
            send_ray(random_ray());
         end
         drain_rays();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: ray_sphere_intersect_top.f
rtl/rsi_pkg.sv
rtl/rsi_quad.sv
rtl/rsi_sqrt.sv
rtl/rsi_div.sv
rtl/ray_sphere_intersect_top.sv
tb/sv/ray_sphere_checker.sv
tb/sv/tb_top.sv
